// ===== design/sua_pkg.sv =====
// Shared types, widths and constants of the sample/upload alarm scheduler.
// Used by sua_cfg, sua_div and sample_upload_alarm_scheduler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sua_pkg;

    localparam int UploadW  = 11;
    localparam int SampleW  = 15;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 15;
    localparam int SecW     = 17;
    localparam int AccW     = 18;
    localparam int CountW   = 14;
    localparam int ProdW    = 15;
    localparam int DivW     = 18;
    localparam int DivSteps = DivW;
    localparam int DivCntW  = $clog2(DivSteps);

    localparam logic [CfgIdxW-1:0] RegUpload = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegSample = CfgIdxW'(1);

    localparam logic [UploadW-1:0] UploadMin   = UploadW'(3);
    localparam logic [UploadW-1:0] UploadMax   = UploadW'(1440);
    localparam logic [UploadW-1:0] UploadReset = UploadW'(1440);
    localparam logic [SampleW-1:0] SampleMin   = SampleW'(2);
    localparam logic [SampleW-1:0] SampleMax   = SampleW'(17280);
    localparam logic [SampleW-1:0] SampleReset = SampleW'(60);

    typedef struct packed {
        logic [UploadW-1:0] upload_minutes;
        logic [SampleW-1:0] sample_units;
    } sua_cfg_t;

    function automatic logic [UploadW-1:0] clamp_upload(input logic [UploadW-1:0] v);
        logic [UploadW-1:0] r;
        r = v;
        if (v < UploadMin) r = UploadMin;
        else if (v > UploadMax) r = UploadMax;
        return r;
    endfunction

    function automatic logic [SampleW-1:0] clamp_sample(input logic [SampleW-1:0] v);
        logic [SampleW-1:0] r;
        r = v;
        if (v < SampleMin) r = SampleMin;
        else if (v > SampleMax) r = SampleMax;
        return r;
    endfunction

    // Units of five seconds to seconds: 4s + s.
    function automatic logic [SecW-1:0] units_to_sec(input logic [SampleW-1:0] s);
        return {2'b00, s} + {s, 2'b00};
    endfunction

    // Minutes to units of five seconds: 8u + 4u.
    function automatic logic [ProdW-1:0] min_to_units(input logic [UploadW-1:0] u);
        return {1'b0, u, 3'b000} + {2'b00, u, 2'b00};
    endfunction

    // Minutes to seconds: 64u - 4u.
    function automatic logic [SecW-1:0] min_to_sec(input logic [UploadW-1:0] u);
        return {u, 6'b000000} - {4'b0000, u, 2'b00};
    endfunction

endpackage

`default_nettype wire

// ===== design/sua_cfg.sv =====
// Configuration register file: upload interval and sample interval.
// Depends on sua_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module sua_cfg
    import sua_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output sua_cfg_t                 regs,
    output logic                     wr_hit
);

    sua_cfg_t regs_reg, regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        wr_hit    = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                RegUpload:
                begin
                    regs_next.upload_minutes = cfg_data[UploadW-1:0];
                    wr_hit = 1'b1;
                end
                RegSample:
                begin
                    regs_next.sample_units = cfg_data[SampleW-1:0];
                    wr_hit = 1'b1;
                end
                default:
                begin
                    regs_next = regs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.upload_minutes <= UploadReset;
            regs_reg.sample_units   <= SampleReset;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sua_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle through a shift register.
// Depends on sua_pkg for the dividend, divisor and step-count widths.
`timescale 1ns / 1ps
`default_nettype none

module sua_div
    import sua_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [DivW-1:0] dividend,
    input  wire logic [SecW-1:0] divisor,
    output logic                 done,
    output logic [DivW-1:0]      quotient,
    output logic [SecW-1:0]      remainder
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic [DivW-1:0]    quo_reg, quo_next;
    logic [SecW-1:0]    rem_reg, rem_next;
    logic [SecW-1:0]    dvs_reg, dvs_next;
    logic [SecW:0]      trial;
    logic [SecW:0]      diff;

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DivW-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DivCntW'(DivSteps - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[SecW-1:0];
                quo_next = {quo_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SecW-1:0];
                quo_next = {quo_reg[DivW-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - DivCntW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

// ===== design/sample_upload_alarm_scheduler.sv =====
// Top level of the sample/upload alarm scheduler: event sequencer and result register.
// Depends on sua_pkg, sua_cfg and sua_div.
//
// Each transfer on the input channel (in_valid, in_stall, restart) is one alarm event.
// The block answers with one transfer on the output channel (out_valid, out_stall):
// seconds until the next alarm, plus whether a sample and/or an upload is due now.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always taken;
// a write to either register marks the schedule for recompute at the next event.
// Writes to an index other than the two registers are ignored.
// A plain sample event passes the alarm and due-flag registers, then the output register.
// Events that recompute the schedule or close an upload period run the bit-serial divider,
// once, or twice when the period remainder is carried over (a modulo and then a division).
// One event is worked on at a time; in_stall is high from the accepting edge until the
// result is placed in the output register.
// The output register holds its result while out_stall is high, and the next event is
// already accepted and worked on meanwhile.
// Reset restores the register defaults and forces a recompute on the first event.
`timescale 1ns / 1ps
`default_nettype none

module sample_upload_alarm_scheduler
    import sua_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                restart,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [SecW-1:0]          next_alarm_seconds,
    output logic                     sample_due,
    output logic                     upload_due,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SPP,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [SecW-1:0]   sd_reg, sd_next;
    logic [SecW-1:0]   ud_reg, ud_next;
    logic [CountW-1:0] spp_reg, spp_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic [AccW-1:0]   acc_reg, acc_next;
    logic              upend_reg, upend_next;
    logic              rp_reg, rp_next;
    logic              plus_one_reg, plus_one_next;
    logic [SecW-1:0]   alarm_reg, alarm_next;
    logic              sdue_reg, sdue_next;
    logic              udue_reg, udue_next;
    logic              out_valid_reg, out_valid_next;
    logic [SecW-1:0]   out_alarm_reg, out_alarm_next;
    logic              out_sdue_reg, out_sdue_next;
    logic              out_udue_reg, out_udue_next;

    sua_cfg_t          cfg_regs;
    logic              cfg_hit;

    logic              div_start;
    logic [DivW-1:0]   div_dividend;
    logic [SecW-1:0]   div_divisor;
    logic              div_done;
    logic [DivW-1:0]   div_quo;
    logic [SecW-1:0]   div_rem;

    logic [UploadW-1:0] u_cl;
    logic [SampleW-1:0] s_cl;
    logic [SecW-1:0]    sd_new;
    logic [SecW-1:0]    ud_new;
    logic [ProdW-1:0]   u12;
    logic [CountW:0]    idx_inc;
    logic [SecW-1:0]    ud_nz;
    logic [SecW-1:0]    sd_nz;

    sua_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg_regs),
        .wr_hit    (cfg_hit)
    );

    sua_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_stall           = (state_reg != ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign next_alarm_seconds = out_alarm_reg;
    assign sample_due         = out_sdue_reg;
    assign upload_due         = out_udue_reg;

    always_comb
    begin
        u_cl    = clamp_upload(cfg_regs.upload_minutes);
        s_cl    = clamp_sample(cfg_regs.sample_units);
        sd_new  = units_to_sec(s_cl);
        ud_new  = min_to_sec(u_cl);
        u12     = min_to_units(u_cl);
        idx_inc = {1'b0, idx_reg} + (CountW + 1)'(1);
        ud_nz   = (ud_reg == '0) ? SecW'(1) : ud_reg;
        sd_nz   = (sd_reg == '0) ? SecW'(1) : sd_reg;

        state_next     = state_reg;
        sd_next        = sd_reg;
        ud_next        = ud_reg;
        spp_next       = spp_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        upend_next     = upend_reg;
        rp_next        = rp_reg;
        plus_one_next  = plus_one_reg;
        alarm_next     = alarm_reg;
        sdue_next      = sdue_reg;
        udue_next      = udue_reg;
        out_valid_next = out_valid_reg;
        out_alarm_next = out_alarm_reg;
        out_sdue_next  = out_sdue_reg;
        out_udue_next  = out_udue_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = SecW'(1);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart || rp_reg)
                    begin
                        sd_next       = sd_new;
                        ud_next       = ud_new;
                        upend_next    = 1'b0;
                        idx_next      = '0;
                        alarm_next    = sd_new;
                        acc_next      = {1'b0, sd_new};
                        rp_next       = 1'b0;
                        sdue_next     = 1'b0;
                        udue_next     = 1'b0;
                        div_start     = 1'b1;
                        div_dividend  = DivW'(u12);
                        div_divisor   = SecW'(s_cl);
                        plus_one_next = 1'b0;
                        state_next    = ST_SPP;
                    end
                    else if (idx_inc < {1'b0, spp_reg})
                    begin
                        sdue_next  = 1'b1;
                        udue_next  = 1'b0;
                        idx_next   = idx_inc[CountW-1:0];
                        alarm_next = sd_reg;
                        acc_next   = acc_reg + AccW'(sd_reg);
                        state_next = ST_OUT;
                    end
                    else if ({1'b0, ud_reg} != acc_reg)
                    begin
                        if (upend_reg)
                        begin
                            // Close the period and carry the overshoot into the next one.
                            upend_next   = 1'b0;
                            sdue_next    = 1'b0;
                            udue_next    = 1'b1;
                            idx_next     = '0;
                            div_start    = 1'b1;
                            div_dividend = DivW'(acc_reg + AccW'(sd_reg));
                            div_divisor  = ud_nz;
                            state_next   = ST_MOD;
                        end
                        else
                        begin
                            sdue_next  = 1'b1;
                            udue_next  = 1'b0;
                            upend_next = 1'b1;
                            if ({1'b0, ud_reg} > acc_reg)
                            begin
                                alarm_next = ud_reg - acc_reg[SecW-1:0];
                            end
                            else
                            begin
                                alarm_next = '0;
                            end
                            state_next = ST_OUT;
                        end
                    end
                    else
                    begin
                        sdue_next     = 1'b1;
                        udue_next     = 1'b1;
                        idx_next      = '0;
                        alarm_next    = sd_reg;
                        acc_next      = {1'b0, sd_reg};
                        div_start     = 1'b1;
                        div_dividend  = DivW'(ud_reg);
                        div_divisor   = sd_nz;
                        plus_one_next = 1'b0;
                        state_next    = ST_SPP;
                    end
                end
            end
            ST_MOD:
            begin
                if (div_done)
                begin
                    // The remainder is below the upload delay, so the difference never wraps.
                    alarm_next    = div_rem;
                    acc_next      = {1'b0, div_rem};
                    div_start     = 1'b1;
                    div_dividend  = DivW'(ud_reg - div_rem);
                    div_divisor   = sd_nz;
                    plus_one_next = 1'b1;
                    state_next    = ST_SPP;
                end
            end
            ST_SPP:
            begin
                if (div_done)
                begin
                    spp_next   = div_quo[CountW-1:0] + CountW'(plus_one_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_alarm_next = alarm_reg;
                    out_sdue_next  = sdue_reg;
                    out_udue_next  = udue_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_hit)
        begin
            rp_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sd_reg        <= '0;
            ud_reg        <= '0;
            spp_reg       <= '0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            upend_reg     <= 1'b0;
            rp_reg        <= 1'b1;
            plus_one_reg  <= 1'b0;
            alarm_reg     <= '0;
            sdue_reg      <= 1'b0;
            udue_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_alarm_reg <= '0;
            out_sdue_reg  <= 1'b0;
            out_udue_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sd_reg        <= sd_next;
            ud_reg        <= ud_next;
            spp_reg       <= spp_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            upend_reg     <= upend_next;
            rp_reg        <= rp_next;
            plus_one_reg  <= plus_one_next;
            alarm_reg     <= alarm_next;
            sdue_reg      <= sdue_next;
            udue_reg      <= udue_next;
            out_valid_reg <= out_valid_next;
            out_alarm_reg <= out_alarm_next;
            out_sdue_reg  <= out_sdue_next;
            out_udue_reg  <= out_udue_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sua_alarm_checker.sv =====
// Checker for the sample/upload alarm scheduler: watches the event, result and
// register-write channels, predicts each result and compares it field by field.
// Depends on sua_pkg for widths, register indexes and register limits.
`timescale 1ns / 1ps

module sua_alarm_checker
    import sua_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic                restart,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [SecW-1:0]     next_alarm_seconds,
    input  wire logic                sample_due,
    input  wire logic                upload_due,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output int                       mismatches,
    output int                       awaited
);

    localparam int unsigned SecPerUnit  = 5;
    localparam int unsigned UnitsPerMin = 12;
    localparam int unsigned SecPerMin   = 60;

    typedef struct packed {
        logic [SecW-1:0] alarm;
        logic            sample;
        logic            upload;
    } alarm_result_t;

    alarm_result_t expected_alarms[$];
    int            results_seen;

    // Register copies and schedule state of the predictor.
    logic [UploadW-1:0] upload_min_reg;
    logic [SampleW-1:0] sample_units_reg;
    logic [SecW-1:0]    sample_step_sec;
    logic [SecW-1:0]    upload_sec;
    logic [CountW-1:0]  period_samples;
    logic [CountW-1:0]  sample_idx;
    logic [AccW-1:0]    elapsed_sec;
    logic               upload_armed;
    logic               recompute_due;

    initial
    begin
        mismatches   = 0;
        awaited      = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic alarm_result_t next_alarm(input logic restart_in);
        int unsigned   u;
        int unsigned   s;
        int unsigned   sd;
        int unsigned   ud;
        int unsigned   carried;
        alarm_result_t r;
        r = '0;
        if (restart_in || recompute_due)
        begin
            u = upload_min_reg;
            s = sample_units_reg;
            if (u < UploadMin) u = UploadMin;
            else if (u > UploadMax) u = UploadMax;
            if (s < SampleMin) s = SampleMin;
            else if (s > SampleMax) s = SampleMax;
            sample_step_sec = SecW'(s * SecPerUnit);
            period_samples  = CountW'((u * UnitsPerMin) / s);
            upload_sec      = SecW'(u * SecPerMin);
            upload_armed    = 1'b0;
            sample_idx      = '0;
            r.alarm         = sample_step_sec;
            elapsed_sec     = AccW'(sample_step_sec);
            recompute_due   = 1'b0;
        end
        else if (sample_idx + 32'd1 < period_samples)
        begin
            r.sample    = 1'b1;
            sample_idx  = sample_idx + 1'b1;
            r.alarm     = sample_step_sec;
            elapsed_sec = AccW'(elapsed_sec + sample_step_sec);
        end
        else if (upload_sec != elapsed_sec)
        begin
            sd = (sample_step_sec != 0) ? sample_step_sec : 1;
            ud = (upload_sec != 0) ? upload_sec : 1;
            if (upload_armed)
            begin
                // Close the period and carry the overshoot into the next one.
                upload_armed = 1'b0;
                r.upload     = 1'b1;
                sample_idx   = '0;
                carried      = AccW'(elapsed_sec + sample_step_sec);
                carried      = carried % ud;
                r.alarm      = SecW'(carried);
                elapsed_sec  = AccW'(carried);
                if (upload_sec >= elapsed_sec)
                    period_samples = CountW'((upload_sec - elapsed_sec) / sd + 1);
                else
                    period_samples = CountW'(1);
            end
            else
            begin
                // Short alarm up to the upload instant; saturates when already past it.
                r.sample     = 1'b1;
                upload_armed = 1'b1;
                if (upload_sec > elapsed_sec)
                    r.alarm = SecW'(upload_sec - elapsed_sec);
                else
                    r.alarm = '0;
            end
        end
        else
        begin
            sd             = (sample_step_sec != 0) ? sample_step_sec : 1;
            r.sample       = 1'b1;
            r.upload       = 1'b1;
            sample_idx     = '0;
            r.alarm        = sample_step_sec;
            elapsed_sec    = AccW'(sample_step_sec);
            period_samples = CountW'(upload_sec / sd);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alarm_result_t want;
        if (!rst_n)
        begin
            upload_min_reg   = UploadReset;
            sample_units_reg = SampleReset;
            sample_step_sec  = '0;
            upload_sec       = '0;
            period_samples   = '0;
            sample_idx       = '0;
            elapsed_sec      = '0;
            upload_armed     = 1'b0;
            recompute_due    = 1'b1;
            expected_alarms.delete();
            awaited          = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_alarms.size() == 0)
                begin
                    report_mismatch("unrequested result, alarm", next_alarm_seconds, 0);
                end
                else
                begin
                    want = expected_alarms.pop_front();
                    if (next_alarm_seconds !== want.alarm)
                        report_mismatch("next_alarm_seconds", next_alarm_seconds, want.alarm);
                    if (sample_due !== want.sample)
                        report_mismatch("sample_due", sample_due, want.sample);
                    if (upload_due !== want.upload)
                        report_mismatch("upload_due", upload_due, want.upload);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == RegUpload)
                begin
                    upload_min_reg = cfg_data[UploadW-1:0];
                    recompute_due  = 1'b1;
                end
                else if (cfg_index == RegSample)
                begin
                    sample_units_reg = cfg_data[SampleW-1:0];
                    recompute_due    = 1'b1;
                end
            end
            if (in_valid && !in_stall)
                expected_alarms.push_back(next_alarm(restart));
            awaited = expected_alarms.size();
        end
    end

endmodule

// ===== tb/sample_upload_alarm_scheduler_test.sv =====
// Top of the sample/upload alarm scheduler testbench: clock, reset, event and
// register-write stimulus, output stall, watchdog and verdict.
// Depends on sua_pkg, the scheduler RTL and sua_alarm_checker.
`timescale 1ns / 1ps

module sample_upload_alarm_scheduler_test;
    import sua_pkg::*;

    localparam int StallLimit  = 3000;
    localparam int HoldCycles  = 300;
    localparam int EventTarget = 900;

    // Indexes that map to no register.
    localparam logic [CfgIdxW-1:0] RegSpareLo = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] RegSpareHi = CfgIdxW'(3);

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                restart   = 1'b0;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                in_stall;
    logic                out_valid;
    logic [SecW-1:0]     next_alarm_seconds;
    logic                sample_due;
    logic                upload_due;
    logic                cfg_ready;

    int mismatch_count;
    int results_awaited;
    int events_sent      = 0;
    int sender_gap_pct   = 29;
    int receiver_gap_pct = 88;
    int quiet_cycles     = 0;
    bit hold_req         = 1'b0;

    sample_upload_alarm_scheduler uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .restart            (restart),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .next_alarm_seconds (next_alarm_seconds),
        .sample_due         (sample_due),
        .upload_due         (upload_due),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    sua_alarm_checker alarm_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .restart            (restart),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .next_alarm_seconds (next_alarm_seconds),
        .sample_due         (sample_due),
        .upload_due         (upload_due),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatch_count),
        .awaited            (results_awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stall, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < receiver_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit)
        begin
            $display("sample_upload_alarm_scheduler regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_event(input logic rs);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do @(posedge clk); while (in_stall);
        events_sent++;
    endtask

    // Registers are only written once every result is back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_awaited != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [CfgDataW-1:0] cfg_word;
        bit                  do_upload;
        bit                  do_sample;
        bit                  pressure_done;
        int                  burst;
        pressure_done = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the first event recomputes from the defaults even without restart.
        repeat (3) send_event(1'b0);
        drain();
        write_reg(RegUpload, CfgDataW'(UploadMin));
        write_reg(RegSample, CfgDataW'(SampleMin));
        repeat (3) send_event(1'b0);
        drain();
        // Both registers out of range; the clamped sample period exceeds the upload
        // period, so the remaining time saturates and the period ends at once.
        write_reg(RegUpload, '0);
        write_reg(RegSample, '1);
        repeat (5) send_event(1'b0);
        drain();
        write_reg(RegUpload, '1);
        write_reg(RegSample, CfgDataW'(1));
        send_event(1'b0);
        send_event(1'b1);
        send_event(1'b0);
        drain();
        // Writes to the spare indexes must not disturb the schedule.
        write_reg(RegSpareLo, '1);
        write_reg(RegSpareHi, '0);
        send_event(1'b0);
        drain();
        // Upload period not a multiple of the sample period: remainder carried over.
        write_reg(RegUpload, CfgDataW'(3));
        write_reg(RegSample, CfgDataW'(7));
        repeat (9) send_event(1'b0);

        while (events_sent < EventTarget)
        begin
            drain();
            if (events_sent >= 2 * EventTarget / 3)
            begin
                sender_gap_pct   = 0;
                receiver_gap_pct = 0;
                if (!pressure_done)
                begin
                    hold_req      = 1'b1;
                    pressure_done = 1'b1;
                end
            end
            else if (events_sent >= EventTarget / 3)
            begin
                sender_gap_pct   = 88;
                receiver_gap_pct = 29;
            end
            do_upload = ($urandom_range(0, 3) != 0);
            do_sample = !do_upload || ($urandom_range(0, 3) != 0);
            if (do_upload)
            begin
                case ($urandom_range(0, 9))
                    0: cfg_word = CfgDataW'($urandom);
                    1: cfg_word = CfgDataW'(UploadMax) + CfgDataW'($urandom_range(0, 1));
                    2: cfg_word = CfgDataW'($urandom_range(0, 2));
                    default: cfg_word = CfgDataW'($urandom_range(UploadMin, 8));
                endcase
                write_reg(RegUpload, cfg_word);
            end
            if (do_sample)
            begin
                case ($urandom_range(0, 9))
                    0: cfg_word = CfgDataW'($urandom);
                    1: cfg_word = CfgDataW'(SampleMax) + CfgDataW'($urandom_range(0, 1));
                    2: cfg_word = CfgDataW'($urandom_range(0, 1));
                    3: cfg_word = CfgDataW'($urandom_range(100, 2000));
                    default: cfg_word = CfgDataW'($urandom_range(SampleMin, 40));
                endcase
                write_reg(RegSample, cfg_word);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? RegSpareHi : RegSpareLo,
                          CfgDataW'($urandom));
            burst = $urandom_range(30, 60);
            repeat (burst) send_event($urandom_range(0, 39) == 0);
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && results_awaited == 0)
            $display("sample_upload_alarm_scheduler regression: pass");
        else
            $display("sample_upload_alarm_scheduler regression: fail");
        $finish;
    end

endmodule

// ===== sample_upload_alarm_scheduler.f =====
design/sua_pkg.sv
design/sua_cfg.sv
design/sua_div.sv
design/sample_upload_alarm_scheduler.sv
tb/sua_alarm_checker.sv
tb/sample_upload_alarm_scheduler_test.sv
